// File: rtl/fbc_pkg.sv
package fbc_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int HALF_ENTRIES = MAX_ENTRIES / 2;

	localparam int FUNC_W = 2;
	localparam int FEAT_W = 6;
	localparam int ENT_W  = 4;
	localparam int VAL_W  = 32;
	localparam int CNT_W  = 5;
	localparam int CAT_W  = 5;
	localparam int STAT_W = 2;
	localparam int FCNT_W = 7;

	localparam logic [FUNC_W-1:0] FUNC_CLASSIFY = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SETKIND  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISS  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [FEAT_W-1:0]       feature;
		logic [ENT_W-1:0]        entry;
		logic signed [VAL_W-1:0] value;
		logic                    discrete_kind;
		logic [CNT_W-1:0]        entry_total;
	} item_t;

	// classify request traveling behind the table read
	typedef struct packed {
		logic                    cls;
		logic                    rng;
		logic signed [VAL_W-1:0] value;
	} ctl_t;

endpackage

// File: rtl/fbc_ram.sv
module fbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/fbc_store.sv
module fbc_store import fbc_pkg::*; #(
	parameter int MAX_FEATURES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_s1,
	input  logic             in_range_s1,
	input  item_t            item_s1,
	output logic [VAL_W-1:0] row_s2 [MAX_ENTRIES],
	output logic             kind_s2,
	output logic [CNT_W-1:0] count_s2
);

	localparam int FEAT_DEPTH = (MAX_FEATURES < (1 << FEAT_W)) ? MAX_FEATURES : (1 << FEAT_W);
	localparam int FA_W = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
	localparam int META_W = CNT_W + 1;

	logic [FA_W-1:0]       addr;
	logic                  act;
	logic                  ent_we;
	logic                  meta_we;
	logic                  rd_en;
	logic [CNT_W-1:0]      total_sat;
	logic [META_W-1:0]     meta_rd;
	logic [FEAT_DEPTH-1:0] meta_vld_q;
	logic                  vld_s2;

	assign addr    = item_s1.feature[FA_W-1:0];
	assign act     = en && vld_s1 && in_range_s1;
	assign ent_we  = act && (item_s1.func == FUNC_WRITE);
	assign meta_we = act && (item_s1.func == FUNC_SETKIND);
	assign rd_en   = act && (item_s1.func == FUNC_CLASSIFY);

	assign total_sat = (item_s1.entry_total > CNT_W'(MAX_ENTRIES)) ?
		CNT_W'(MAX_ENTRIES) : item_s1.entry_total;

	// one narrow bank per entry column so a whole row reads in one cycle
	for (genvar e = 0; e < MAX_ENTRIES; e++) begin : g_col
		fbc_ram #(
			.WIDTH(VAL_W),
			.DEPTH(FEAT_DEPTH)
		) u_col (
			.clk   (clk),
			.we    (ent_we && (item_s1.entry == ENT_W'(e))),
			.waddr (addr),
			.wdata (item_s1.value),
			.re    (rd_en),
			.raddr (addr),
			.rdata (row_s2[e])
		);
	end

	fbc_ram #(
		.WIDTH(META_W),
		.DEPTH(FEAT_DEPTH)
	) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (addr),
		.wdata ({item_s1.discrete_kind, total_sat}),
		.re    (rd_en),
		.raddr (addr),
		.rdata (meta_rd)
	);

	// meta entries never set since reset read as continuous, empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_vld_q <= '0;
			vld_s2     <= 1'b0;
		end else begin
			if (meta_we) begin
				meta_vld_q[addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s2 <= meta_vld_q[addr];
			end
		end
	end

	assign kind_s2  = vld_s2 && meta_rd[CNT_W];
	assign count_s2 = vld_s2 ? meta_rd[CNT_W-1:0] : '0;

endmodule

// File: rtl/fbc_match.sv
module fbc_match import fbc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ctl_t              ctl_s2,
	input  logic [VAL_W-1:0]  row_s2 [MAX_ENTRIES],
	input  logic              kind_s2,
	input  logic [CNT_W-1:0]  count_s2,
	output logic              res_valid,
	output logic [CAT_W-1:0]  category,
	output logic [STAT_W-1:0] status
);

	logic [MAX_ENTRIES-1:0] hit;
	logic [MAX_ENTRIES-1:0] hit_s3;
	logic                   cls_s3;
	logic                   rng_s3;
	logic                   kind_s3;
	logic [CNT_W-1:0]       count_s3;
	logic                   lo_any;
	logic                   hi_any;
	logic [CAT_W-1:0]       lo_idx;
	logic [CAT_W-1:0]       hi_idx;
	logic [CAT_W-1:0]       cat_nx;
	logic [STAT_W-1:0]      st_nx;

	// discrete: equal; continuous: sample below edge; only entries under the count
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit[i] = (CNT_W'(i) < count_s2) &&
				(kind_s2 ? (ctl_s2.value == $signed(row_s2[i])) :
				           (ctl_s2.value < $signed(row_s2[i])));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_s3 <= 1'b0;
		end else if (en) begin
			cls_s3 <= ctl_s2.cls;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3   <= hit;
			rng_s3   <= ctl_s2.rng;
			kind_s3  <= kind_s2;
			count_s3 <= count_s2;
		end
	end

	// first hit, searched as two halves
	always_comb begin
		lo_idx = '0;
		hi_idx = '0;
		for (int i = HALF_ENTRIES - 1; i >= 0; i--) begin
			if (hit_s3[i]) begin
				lo_idx = CAT_W'(i);
			end
		end
		for (int i = MAX_ENTRIES - 1; i >= HALF_ENTRIES; i--) begin
			if (hit_s3[i]) begin
				hi_idx = CAT_W'(i);
			end
		end
	end

	assign lo_any = |hit_s3[HALF_ENTRIES-1:0];
	assign hi_any = |hit_s3[MAX_ENTRIES-1:HALF_ENTRIES];

	always_comb begin
		cat_nx = '0;
		st_nx  = ST_OK;
		if (!rng_s3) begin
			st_nx = ST_RANGE;
		end else if (lo_any) begin
			cat_nx = lo_idx;
		end else if (hi_any) begin
			cat_nx = hi_idx;
		end else if (kind_s3) begin
			st_nx = ST_MISS;
		end else begin
			cat_nx = CAT_W'(count_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= cls_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			category <= cat_nx;
			status   <= st_nx;
		end
	end

	a_range_cat: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status == ST_RANGE) |-> (category == '0))
		else $error("out-of-range request with nonzero category");

	a_miss_cat: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status == ST_MISS) |-> (category == '0))
		else $error("missed discrete value with nonzero category");

	a_cat_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (category <= CAT_W'(MAX_ENTRIES)))
		else $error("category beyond entry count");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(en && cls_s3) |=> res_valid)
		else $error("classify request lost at output stage");

endmodule

// File: rtl/feature_bin_categorizer.sv
// channel   | valid      | stall      | payload
// request   | req_valid  | req_stall  | func feature entry value discrete_kind entry_total
// result    | res_valid  | res_stall  | category status
// config    | cfg_wr_en  | -          | cfg_wr_data (feature_count)
//
// One request per cycle unless stalled; a classify result passes through the
// table row read, per-entry compare and first-hit encode behind the input register.
// Every entry of a row sits in its own column bank, so one read gets the row.
// Write and set-kind requests give no result. Reset clears feature_count and
// the per-feature kind/count valid bits; table entries hold garbage until written.
// A stalled result freezes the whole pipe, req_stall follows at once.
module feature_bin_categorizer import fbc_pkg::*; #(
	parameter int MAX_FEATURES = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [FCNT_W-1:0]       cfg_wr_data,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [FUNC_W-1:0]       func,
	input  logic [FEAT_W-1:0]       feature,
	input  logic [ENT_W-1:0]        entry,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    discrete_kind,
	input  logic [CNT_W-1:0]        entry_total,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [CAT_W-1:0]        category,
	output logic [STAT_W-1:0]       status
);

	logic              en;
	logic [FCNT_W-1:0] feat_cnt_q;
	logic              vld_s1;
	item_t             item_s1;
	logic              in_range_s1;
	ctl_t              ctl_s2;
	logic [VAL_W-1:0]  row_s2 [MAX_ENTRIES];
	logic              kind_s2;
	logic [CNT_W-1:0]  count_s2;

	assign en        = !(res_valid && res_stall);
	assign req_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feat_cnt_q <= '0;
		end else if (cfg_wr_en) begin
			feat_cnt_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			ctl_s2 <= '0;
		end else if (en) begin
			vld_s1       <= req_valid;
			ctl_s2.cls   <= vld_s1 && (item_s1.func == FUNC_CLASSIFY);
			ctl_s2.rng   <= in_range_s1;
			ctl_s2.value <= item_s1.value;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.func          <= func;
			item_s1.feature       <= feature;
			item_s1.entry         <= entry;
			item_s1.value         <= value;
			item_s1.discrete_kind <= discrete_kind;
			item_s1.entry_total   <= entry_total;
		end
	end

	assign in_range_s1 = ({1'b0, item_s1.feature} < feat_cnt_q) &&
		(32'(item_s1.feature) < MAX_FEATURES);

	fbc_store #(
		.MAX_FEATURES(MAX_FEATURES)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.vld_s1      (vld_s1),
		.in_range_s1 (in_range_s1),
		.item_s1     (item_s1),
		.row_s2      (row_s2),
		.kind_s2     (kind_s2),
		.count_s2    (count_s2)
	);

	fbc_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_s2    (ctl_s2),
		.row_s2    (row_s2),
		.kind_s2   (kind_s2),
		.count_s2  (count_s2),
		.res_valid (res_valid),
		.category  (category),
		.status    (status)
	);

endmodule
